@@ hw/rtl/ttac_pkg.sv @@
package ttac_pkg;

  // signed width for aim centre and deviation arithmetic
  localparam int DEV_W = 13;

  localparam logic REQ_DET = 1'b0;
  localparam logic REQ_EOF = 1'b1;

  localparam logic [1:0] LASER_LEAVE = 2'd0;
  localparam logic [1:0] LASER_ON    = 2'd1;
  localparam logic [1:0] LASER_OFF   = 2'd2;

  localparam logic [1:0] REG_X_OFFSET    = 2'd0;
  localparam logic [1:0] REG_Y_OFFSET    = 2'd1;
  localparam logic [1:0] REG_MIN_SPEED_X = 2'd2;
  localparam logic [1:0] REG_MIN_SPEED_Y = 2'd3;

  localparam int          OFFSET_MID    = 25;
  localparam logic [17:0] DIST_SQ_MAX   = 18'h3FFFF;
  localparam logic [24:0] GATE_ALL_ONES = 25'h1FFFFFF;
  localparam logic [24:0] GATE_FLOOR    = 25'd10000;
  localparam logic [3:0]  SHOOT_FRAMES  = 4'd10;
  localparam logic [4:0]  TRACK_NEW     = 5'd10;
  localparam logic [4:0]  TRACK_HOLD    = 5'd20;
  localparam logic [6:0]  VEL_MAX       = 7'd100;

  typedef struct packed {
    logic       req_type;
    logic [9:0] circle_x;
    logic [8:0] circle_y;
    logic [5:0] circle_radius;
  } req_t;

  typedef struct packed {
    logic [1:0]        laser_cmd;
    logic              motors_update;
    logic signed [7:0] pan_velocity;
    logic signed [7:0] tilt_velocity;
    logic              target_seen;
  } res_t;

  // end of frame hand-off from tracking to aiming
  typedef struct packed {
    logic                    kept;
    logic signed [DEV_W-1:0] dev_x;
    logic signed [DEV_W-1:0] dev_y;
    logic [5:0]              rad;
  } aim_t;

endpackage

@@ hw/rtl/ttac_chan_if.sv @@
interface ttac_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

@@ hw/rtl/ttac_axis.sv @@
module ttac_axis import ttac_pkg::*; #(
  parameter int SPAN = 640
) (
  input  logic signed [DEV_W-1:0] dev,
  input  logic [5:0]              rad,
  input  logic [4:0]              min_spd,
  output logic signed [7:0]       vel
);

  // exact floor(200*n/SPAN) for n < SPAN/2 via ceil reciprocal
  localparam int              SHIFT = 2 * $clog2(SPAN) + 1;
  localparam longint unsigned RECIP = ((longint'(200) << SHIFT) + SPAN - 1) / SPAN;
  localparam int              RCW   = $clog2(RECIP + 1);
  localparam int              PW    = DEV_W + RCW;

  logic [DEV_W-1:0] adev;
  logic [DEV_W+1:0] dev3;
  logic [PW-1:0]    prod;
  logic [6:0]       quo;
  logic [6:0]       mag;
  logic             dead;
  logic             sat;

  always_comb begin
    adev = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
    dev3 = {2'b00, adev} + {1'b0, adev, 1'b0};
    dead = dev3 <= (DEV_W+2)'({rad, 1'b0});
    sat  = {adev, 1'b0} >= (DEV_W+1)'(SPAN);
    prod = PW'(adev) * PW'(RECIP);
    quo  = prod[SHIFT +: 7];
    if (dead) begin
      mag = 7'd0;
    end else if (sat) begin
      mag = VEL_MAX;
    end else if (quo != 7'd0 && quo < {2'b00, min_spd}) begin
      mag = {2'b00, min_spd};
    end else begin
      mag = quo;
    end
    // drive against the deviation
    vel = dev[DEV_W-1] ? signed'({1'b0, mag}) : -signed'({1'b0, mag});
  end

endmodule

@@ hw/rtl/ttac_track.sv @@
module ttac_track import ttac_pkg::*; #(
  parameter int RADIUS_MAX = 40
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  req_t                    item,
  input  logic signed [DEV_W-1:0] cx,
  input  logic signed [DEV_W-1:0] cy,
  output aim_t                    aim
);

  logic signed [DEV_W-1:0] dx;
  logic signed [DEV_W-1:0] dy;
  logic [2*DEV_W-1:0]      sqx;
  logic [2*DEV_W-1:0]      sqy;
  logic [2*DEV_W:0]        d2;
  logic [17:0]             d2_sat;
  logic [5:0]              rad_c;
  logic                    take;

  logic        found_r;
  logic [17:0] bdist_r;
  logic [9:0]  bcol_r;
  logic [8:0]  brow_r;
  logic [5:0]  brad_r;
  logic [4:0]  track_r, track_nxt;
  logic [24:0] gate_r, gate_nxt;
  logic        gate_inf_r, gate_inf_nxt;

  logic [4:0]  track_aged;
  logic [22:0] main_s;
  logic [24:0] gate49;
  logic        drop;

  // running nearest detection
  always_comb begin
    dx     = signed'({{(DEV_W-10){1'b0}}, item.circle_x}) - cx;
    dy     = signed'({{(DEV_W-9){1'b0}}, item.circle_y}) - cy;
    sqx    = dx * dx;
    sqy    = dy * dy;
    d2     = {1'b0, sqx} + {1'b0, sqy};
    d2_sat = (d2 > (2*DEV_W+1)'(DIST_SQ_MAX)) ? DIST_SQ_MAX : d2[17:0];
    rad_c  = (int'(item.circle_radius) > RADIUS_MAX) ? 6'(RADIUS_MAX) : item.circle_radius;
    take   = !found_r || (d2_sat < bdist_r);
  end

  // tracking gate at end of frame
  always_comb begin
    track_aged   = (track_r != 5'd0) ? track_r - 5'd1 : track_r;
    main_s       = 23'(bdist_r) * 23'd25;
    gate49       = 25'(bdist_r) * 25'd49;
    drop         = 1'b0;
    gate_nxt     = gate_r;
    gate_inf_nxt = gate_inf_r;
    track_nxt    = track_aged;
    priority if (track_aged != 5'd0 && !gate_inf_r &&
                 (!found_r || gate_r < 25'(main_s))) begin
      drop = 1'b1;
    end else if (track_aged != 5'd0 && found_r &&
                 (gate_inf_r || gate_r > 25'(main_s))) begin
      gate_nxt     = gate49;
      gate_inf_nxt = 1'b0;
      track_nxt    = TRACK_HOLD;
    end else if (track_aged == 5'd0) begin
      gate_nxt     = found_r ? gate49 : GATE_ALL_ONES;
      gate_inf_nxt = !found_r;
      track_nxt    = TRACK_NEW;
    end else begin
      track_nxt = track_aged;
    end
    if (!gate_inf_nxt && gate_nxt < GATE_FLOOR) begin
      gate_nxt = GATE_FLOOR;
    end
  end

  assign aim.kept  = found_r && !drop;
  assign aim.dev_x = cx - signed'({{(DEV_W-10){1'b0}}, bcol_r});
  assign aim.dev_y = cy - signed'({{(DEV_W-9){1'b0}}, brow_r});
  assign aim.rad   = brad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      track_r    <= 5'd0;
      gate_r     <= GATE_ALL_ONES;
      gate_inf_r <= 1'b1;
    end else if (go) begin
      if (item.req_type == REQ_DET) begin
        if (take) begin
          found_r <= 1'b1;
        end
      end else begin
        found_r    <= 1'b0;
        track_r    <= track_nxt;
        gate_r     <= gate_nxt;
        gate_inf_r <= gate_inf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && item.req_type == REQ_DET && take) begin
      bdist_r <= d2_sat;
      bcol_r  <= item.circle_x;
      brow_r  <= item.circle_y;
      brad_r  <= rad_c;
    end
  end

  a_track_range: assert property (@(posedge clk) disable iff (!rst_n)
    track_r <= TRACK_HOLD)
    else $error("track count out of range");

  a_gate_floor: assert property (@(posedge clk) disable iff (!rst_n)
    !gate_inf_r |-> gate_r >= GATE_FLOOR)
    else $error("finite gate below floor");

  a_gate_inf: assert property (@(posedge clk) disable iff (!rst_n)
    gate_inf_r |-> gate_r == GATE_ALL_ONES)
    else $error("infinite gate not all ones");

endmodule

@@ hw/rtl/ttac_aim.sv @@
module ttac_aim import ttac_pkg::*; #(
  parameter int FRAME_W = 640,
  parameter int FRAME_H = 480
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  aim_t       aim,
  input  logic [4:0] min_x,
  input  logic [4:0] min_y,
  output res_t       res
);

  logic [2*DEV_W-1:0] sqx;
  logic [2*DEV_W-1:0] sqy;
  logic [2*DEV_W:0]   d2e;
  logic [11:0]        rsq;
  logic               shoot;
  logic [3:0]         shoot_r, shoot_nxt;
  logic [3:0]         shoot_aged;
  logic signed [7:0]  vel_x;
  logic signed [7:0]  vel_y;

  ttac_axis #(.SPAN(FRAME_W)) u_pan (
    .dev     (aim.dev_x),
    .rad     (aim.rad),
    .min_spd (min_x),
    .vel     (vel_x)
  );

  ttac_axis #(.SPAN(FRAME_H)) u_tilt (
    .dev     (aim.dev_y),
    .rad     (aim.rad),
    .min_spd (min_y),
    .vel     (vel_y)
  );

  always_comb begin
    sqx        = aim.dev_x * aim.dev_x;
    sqy        = aim.dev_y * aim.dev_y;
    d2e        = {1'b0, sqx} + {1'b0, sqy};
    rsq        = 12'(aim.rad) * 12'(aim.rad);
    // on target when 1.5*dist < radius
    shoot      = aim.kept && ((31'(d2e) * 31'd9) < 31'({rsq, 2'b00}));
    shoot_aged = (shoot_r != 4'd0) ? shoot_r - 4'd1 : shoot_r;
    shoot_nxt  = shoot ? SHOOT_FRAMES : shoot_aged;

    res.laser_cmd     = (shoot_aged == 4'd0) ? LASER_OFF : LASER_LEAVE;
    res.motors_update = 1'b1;
    res.pan_velocity  = 8'sd0;
    res.tilt_velocity = 8'sd0;
    res.target_seen   = aim.kept;
    if (shoot) begin
      res.laser_cmd     = LASER_ON;
      res.motors_update = 1'b0;
    end else if (aim.kept) begin
      res.pan_velocity  = vel_x;
      res.tilt_velocity = vel_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shoot_r <= 4'd0;
    end else if (go) begin
      shoot_r <= shoot_nxt;
    end
  end

  a_shoot_range: assert property (@(posedge clk) disable iff (!rst_n)
    shoot_r <= SHOOT_FRAMES)
    else $error("shoot count out of range");

endmodule

@@ hw/rtl/turret_target_aim_controller_unit.sv @@
// turret aim controller: takes one word per cycle on in_req, either a circle detection or an
// end-of-frame marker, and returns one word on out_res per end-of-frame marker (detections
// return nothing). throughput is one word per clock with no stall unless out_res backs up;
// an end-of-frame word is taken into the input register and passes on through the two
// register stages behind it: the tracking stage (nearest detection, tracking gate
// bookkeeping) and the aiming stage (exact distance, laser decision, shoot counter,
// pan/tilt velocity).
// the result register lets new words in while a result waits. registers on the apb port:
// 0x0 x_offset, 0x4 y_offset, 0x8 min_speed_x, 0xc min_speed_y; write them only while idle.
module turret_target_aim_controller_unit import ttac_pkg::*; #(
  parameter int FRAME_W    = 640,
  parameter int FRAME_H    = 480,
  parameter int RADIUS_MAX = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  ttac_chan_if.sink   in_req,
  ttac_chan_if.source out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // config registers
  logic [5:0] x_off_r;
  logic [5:0] y_off_r;
  logic [4:0] min_x_r;
  logic [4:0] min_y_r;
  logic       cfg_wr;

  // pipeline
  logic v0_r;
  req_t r0_r;
  logic v1_r;
  aim_t a1_r;
  logic vo_r;
  res_t o_r;

  logic is_eof;
  logic go1;
  logic go2;
  logic in_take;

  logic signed [DEV_W-1:0] cx;
  logic signed [DEV_W-1:0] cy;
  aim_t aim_w;
  res_t res_w;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r <= 6'd25;
      y_off_r <= 6'd25;
      min_x_r <= 5'd11;
      min_y_r <= 5'd11;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_X_OFFSET:    x_off_r <= pwdata[5:0];
        REG_Y_OFFSET:    y_off_r <= pwdata[5:0];
        REG_MIN_SPEED_X: min_x_r <= pwdata[4:0];
        REG_MIN_SPEED_Y: min_y_r <= pwdata[4:0];
        default:         x_off_r <= x_off_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_X_OFFSET:    prdata = 32'(x_off_r);
      REG_Y_OFFSET:    prdata = 32'(y_off_r);
      REG_MIN_SPEED_X: prdata = 32'(min_x_r);
      REG_MIN_SPEED_Y: prdata = 32'(min_y_r);
      default:         prdata = 32'd0;
    endcase
  end

  // aim centre, offset of 25 means no shift
  assign cx = DEV_W'(FRAME_W / 2) + DEV_W'(x_off_r) - DEV_W'(OFFSET_MID);
  assign cy = DEV_W'(FRAME_H / 2) + DEV_W'(y_off_r) - DEV_W'(OFFSET_MID);

  // flow control: detections retire in the tracking stage, only end of frame moves on
  assign is_eof  = (r0_r.req_type == REQ_EOF);
  assign go2     = v1_r && (!vo_r || out_res.ready);
  assign go1     = v0_r && (!is_eof || !v1_r || go2);
  assign in_take = in_req.valid && in_req.ready;

  assign in_req.ready    = !v0_r || go1;
  assign out_res.valid   = vo_r;
  assign out_res.payload = o_r;

  ttac_track #(.RADIUS_MAX(RADIUS_MAX)) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go1),
    .item  (r0_r),
    .cx    (cx),
    .cy    (cy),
    .aim   (aim_w)
  );

  ttac_aim #(.FRAME_W(FRAME_W), .FRAME_H(FRAME_H)) u_aim (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go2),
    .aim   (a1_r),
    .min_x (min_x_r),
    .min_y (min_y_r),
    .res   (res_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (in_take) begin
        v0_r <= 1'b1;
      end else if (go1) begin
        v0_r <= 1'b0;
      end
      if (go1 && is_eof) begin
        v1_r <= 1'b1;
      end else if (go2) begin
        v1_r <= 1'b0;
      end
      if (go2) begin
        vo_r <= 1'b1;
      end else if (out_res.ready) begin
        vo_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      r0_r <= in_req.payload;
    end
    if (go1 && is_eof) begin
      a1_r <= aim_w;
    end
    if (go2) begin
      o_r <= res_w;
    end
  end

  a_only_eof_moves: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v1_r) |-> $past(v0_r && r0_r.req_type == REQ_EOF))
    else $error("aim stage loaded without end of frame word");

endmodule
